### rtl/aabb_collision_resolver_top_macros.svh
// Assertion macros shared by the box collision resolver RTL.
// Included by files that carry concurrent checks; needs aclk and aresetn in scope.
`ifndef AABB_COLLISION_RESOLVER_TOP_MACROS_SVH
`define AABB_COLLISION_RESOLVER_TOP_MACROS_SVH

// same-cycle implication
`define ACR_CHECK(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ACR_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/acr_pkg.sv
// Types, widths and codes for the box collision resolver.
// Used by acr_box_table, acr_gap_unit and aabb_collision_resolver_top.
`timescale 1ns / 1ps

package acr_pkg;

    localparam int COORD_W = 16;
    localparam int SIZE_W  = 15;
    localparam int EDGE_W  = 18;
    localparam int DEPTH_W = 17;
    localparam int POS_W   = 24;
    localparam int SUM_W   = 26;
    localparam int KIND_W  = 2;
    localparam int DIR_W   = 3;

    localparam logic CMD_STORE   = 1'b0;
    localparam logic CMD_RESOLVE = 1'b1;

    localparam logic [KIND_W-1:0] KIND_STORED    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FULL      = 2'd1;
    localparam logic [KIND_W-1:0] KIND_COLLISION = 2'd2;
    localparam logic [KIND_W-1:0] KIND_FINISHED  = 2'd3;

    localparam logic [DIR_W-1:0] DIR_NONE  = 3'd0;
    localparam logic [DIR_W-1:0] DIR_RIGHT = 3'd1;
    localparam logic [DIR_W-1:0] DIR_LEFT  = 3'd2;
    localparam logic [DIR_W-1:0] DIR_DOWN  = 3'd3;
    localparam logic [DIR_W-1:0] DIR_UP    = 3'd4;

    typedef struct packed {
        logic signed [COORD_W-1:0] left;
        logic signed [COORD_W-1:0] top;
        logic [SIZE_W-1:0]         width;
        logic [SIZE_W-1:0]         height;
    } box_t;

    typedef struct packed {
        logic               hit;
        logic [DEPTH_W-1:0] gl;
        logic [DEPTH_W-1:0] gr;
        logic [DEPTH_W-1:0] gu;
        logic [DEPTH_W-1:0] gd;
    } gap_res_t;

    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] lo;
        logic signed [SUM_W-1:0] hi;
        lo = {{(SUM_W-POS_W+1){1'b1}}, {(POS_W-1){1'b0}}};
        hi = {{(SUM_W-POS_W+1){1'b0}}, {(POS_W-1){1'b1}}};
        if (v < lo) begin
            return lo[POS_W-1:0];
        end else if (v > hi) begin
            return hi[POS_W-1:0];
        end
        return v[POS_W-1:0];
    endfunction

endpackage

### rtl/acr_box_table.sv
// Box store: one write port and one registered read port.
// Depends on acr_pkg for the box entry type.
`timescale 1ns / 1ps

module acr_box_table #(
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  acr_pkg::box_t            wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output acr_pkg::box_t            rd_data
);

    acr_pkg::box_t mem [DEPTH];
    acr_pkg::box_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/acr_gap_unit.sv
// Shared gap unit: overlap test and the four absolute edge gaps of one box.
// Depends on acr_pkg; result is registered.
`timescale 1ns / 1ps

module acr_gap_unit (
    input  logic               aclk,
    input  acr_pkg::box_t      query,
    input  acr_pkg::box_t      entry,
    output acr_pkg::gap_res_t  result
);

    localparam int EW = acr_pkg::EDGE_W;

    function automatic logic [acr_pkg::DEPTH_W-1:0] abs_gap(input logic signed [EW-1:0] v);
        logic signed [EW-1:0] n;
        n = -v;
        return v[EW-1] ? n[acr_pkg::DEPTH_W-1:0] : v[acr_pkg::DEPTH_W-1:0];
    endfunction

    logic signed [EW-1:0] q_l, q_t, q_r, q_b;
    logic signed [EW-1:0] e_l, e_t, e_r, e_b;
    logic                 same;
    logic                 overlap;
    acr_pkg::gap_res_t    result_next;
    acr_pkg::gap_res_t    result_reg;

    always_comb begin
        q_l = EW'(query.left);
        q_t = EW'(query.top);
        q_r = q_l + $signed({3'b000, query.width});
        q_b = q_t + $signed({3'b000, query.height});
        e_l = EW'(entry.left);
        e_t = EW'(entry.top);
        e_r = e_l + $signed({3'b000, entry.width});
        e_b = e_t + $signed({3'b000, entry.height});

        same    = (query == entry);
        overlap = (q_l < q_r) && (e_l < e_r) && (q_t < q_b) && (e_t < e_b) &&
                  (q_l < e_r) && (e_l < q_r) && (q_t < e_b) && (e_t < q_b);

        result_next.hit = overlap && !same;
        result_next.gl  = abs_gap(q_r - e_l);
        result_next.gr  = abs_gap(q_l - e_r);
        result_next.gu  = abs_gap(q_b - e_t);
        result_next.gd  = abs_gap(q_t - e_b);
    end

    always_ff @(posedge aclk) begin
        result_reg <= result_next;
    end

    assign result = result_reg;

endmodule

### rtl/aabb_collision_resolver_top.sv
// Box collision resolver top level: sequencer, running position, result register.
// Depends on acr_pkg, acr_box_table, acr_gap_unit and the assertion macro header.
//
// Usage:
//   Input channel s_*: a store item (command 0) appends its box to the table, or
//   reports a full table; a resolve item (command 1) pushes pos_x/pos_y out of
//   every stored box that strictly overlaps the query box and is not identical.
//   Result channel m_*: one result per store; per resolve one collision record
//   per overlapping box in store order, then a finished result with last set.
//   Sequence: a store goes to the store state, which writes its result once the
//   output register is free; a resolve steps each stored box through table read,
//   gap unit, and compare and move, then ends in the finished state; the shared
//   gap unit and the single table read port set this order.
//   s_ready is high only while the sequencer is idle; a result waiting in the
//   output register does not block acceptance of the next item.
//   When the receiver stalls, the walk holds at the next result until the
//   output register is free.
//   Reset (aresetn low, synchronous) empties the table and clears the running
//   position and all handshake state; no clearing pass is needed.
`timescale 1ns / 1ps
`include "aabb_collision_resolver_top_macros.svh"

module aabb_collision_resolver_top #(
    parameter int MAX_BOXES = 16
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic                                   s_command,
    input  logic signed [acr_pkg::COORD_W-1:0]     s_box_left,
    input  logic signed [acr_pkg::COORD_W-1:0]     s_box_top,
    input  logic [acr_pkg::SIZE_W-1:0]             s_box_width,
    input  logic [acr_pkg::SIZE_W-1:0]             s_box_height,
    input  logic signed [acr_pkg::POS_W-1:0]       s_pos_x,
    input  logic signed [acr_pkg::POS_W-1:0]       s_pos_y,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic [acr_pkg::KIND_W-1:0]             m_kind,
    output logic [acr_pkg::DIR_W-1:0]              m_direction,
    output logic [acr_pkg::DEPTH_W-1:0]            m_depth,
    output logic signed [acr_pkg::POS_W-1:0]       m_new_pos_x,
    output logic signed [acr_pkg::POS_W-1:0]       m_new_pos_y,
    output logic                                   m_last
);

    localparam int IDX_W = $clog2(MAX_BOXES);
    localparam int CNT_W = $clog2(MAX_BOXES + 1);
    localparam int PW    = acr_pkg::POS_W;
    localparam int SW    = acr_pkg::SUM_W;
    localparam int DW    = acr_pkg::DEPTH_W;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_STORE = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;
    localparam logic [2:0] ST_GAP   = 3'd3;
    localparam logic [2:0] ST_MOVE  = 3'd4;
    localparam logic [2:0] ST_FINAL = 3'd5;

    logic [2:0]               state_reg, state_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [CNT_W-1:0]         idx_reg, idx_next;
    logic                     full_reg, full_next;
    logic signed [PW-1:0]     run_x_reg, run_x_next;
    logic signed [PW-1:0]     run_y_reg, run_y_next;
    acr_pkg::box_t            query_reg;

    logic                          m_valid_reg, m_valid_next;
    logic [acr_pkg::KIND_W-1:0]    m_kind_reg, m_kind_next;
    logic [acr_pkg::DIR_W-1:0]     m_dir_reg, m_dir_next;
    logic [DW-1:0]                 m_depth_reg, m_depth_next;
    logic signed [PW-1:0]          m_x_reg, m_x_next;
    logic signed [PW-1:0]          m_y_reg, m_y_next;
    logic                          m_last_reg, m_last_next;

    acr_pkg::box_t            in_box;
    acr_pkg::box_t            rd_box;
    acr_pkg::gap_res_t        gap;
    logic                     s_fire;
    logic                     slot_free;
    logic                     table_full;
    logic                     wr_en;

    logic                     l_min, r_min, u_min, d_min;
    logic [acr_pkg::DIR_W-1:0] dir;
    logic [DW-1:0]            min_lr, min_ud, depth;
    logic signed [SW-1:0]     dx, dy;
    logic signed [PW-1:0]     moved_x, moved_y;

    assign in_box.left   = s_box_left;
    assign in_box.top    = s_box_top;
    assign in_box.width  = s_box_width;
    assign in_box.height = s_box_height;

    assign s_ready    = (state_reg == ST_IDLE);
    assign s_fire     = s_valid && s_ready;
    assign slot_free  = !m_valid_reg || m_ready;
    assign table_full = (count_reg == CNT_W'(MAX_BOXES));
    assign wr_en      = s_fire && (s_command == acr_pkg::CMD_STORE) && !table_full;

    acr_box_table #(
        .DEPTH (MAX_BOXES)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_data (in_box),
        .rd_addr (idx_reg[IDX_W-1:0]),
        .rd_data (rd_box)
    );

    acr_gap_unit u_gap (
        .aclk   (aclk),
        .query  (query_reg),
        .entry  (rd_box),
        .result (gap)
    );

    always_comb begin
        l_min  = (gap.gl < gap.gr) && (gap.gl < gap.gu) && (gap.gl < gap.gd);
        r_min  = (gap.gr < gap.gl) && (gap.gr < gap.gu) && (gap.gr < gap.gd);
        u_min  = (gap.gu < gap.gl) && (gap.gu < gap.gr) && (gap.gu < gap.gd);
        d_min  = (gap.gd < gap.gl) && (gap.gd < gap.gr) && (gap.gd < gap.gu);
        min_lr = (gap.gl < gap.gr) ? gap.gl : gap.gr;
        min_ud = (gap.gu < gap.gd) ? gap.gu : gap.gd;
        depth  = (min_lr < min_ud) ? min_lr : min_ud;

        dir = acr_pkg::DIR_NONE;
        dx  = '0;
        dy  = '0;
        if (l_min) begin
            dir = acr_pkg::DIR_RIGHT;
            dx  = SW'(1) - SW'(gap.gl);
        end else if (r_min) begin
            dir = acr_pkg::DIR_LEFT;
            dx  = SW'(gap.gr) - SW'(1);
        end else if (u_min) begin
            dir = acr_pkg::DIR_DOWN;
            dy  = SW'(1) - SW'(gap.gu);
        end else if (d_min) begin
            dir = acr_pkg::DIR_UP;
            dy  = SW'(gap.gd) - SW'(1);
        end
        moved_x = acr_pkg::sat_pos(SW'(run_x_reg) + dx);
        moved_y = acr_pkg::sat_pos(SW'(run_y_reg) + dy);
    end

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        full_next    = full_reg;
        run_x_next   = run_x_reg;
        run_y_next   = run_y_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_kind_next  = m_kind_reg;
        m_dir_next   = m_dir_reg;
        m_depth_next = m_depth_reg;
        m_x_next     = m_x_reg;
        m_y_next     = m_y_reg;
        m_last_next  = m_last_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    if (s_command == acr_pkg::CMD_STORE) begin
                        full_next  = table_full;
                        state_next = ST_STORE;
                        if (!table_full) begin
                            count_next = count_reg + CNT_W'(1);
                        end
                    end else begin
                        run_x_next = s_pos_x;
                        run_y_next = s_pos_y;
                        idx_next   = '0;
                        state_next = ST_READ;
                    end
                end
            end
            ST_STORE: begin
                if (slot_free) begin
                    m_valid_next = 1'b1;
                    m_kind_next  = full_reg ? acr_pkg::KIND_FULL : acr_pkg::KIND_STORED;
                    m_dir_next   = acr_pkg::DIR_NONE;
                    m_depth_next = '0;
                    m_x_next     = '0;
                    m_y_next     = '0;
                    m_last_next  = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_READ: begin
                state_next = (idx_reg == count_reg) ? ST_FINAL : ST_GAP;
            end
            ST_GAP: begin
                state_next = ST_MOVE;
            end
            ST_MOVE: begin
                if (!gap.hit) begin
                    idx_next   = idx_reg + CNT_W'(1);
                    state_next = ST_READ;
                end else if (slot_free) begin
                    run_x_next   = moved_x;
                    run_y_next   = moved_y;
                    m_valid_next = 1'b1;
                    m_kind_next  = acr_pkg::KIND_COLLISION;
                    m_dir_next   = dir;
                    m_depth_next = depth;
                    m_x_next     = moved_x;
                    m_y_next     = moved_y;
                    m_last_next  = 1'b0;
                    idx_next     = idx_reg + CNT_W'(1);
                    state_next   = ST_READ;
                end
            end
            ST_FINAL: begin
                if (slot_free) begin
                    m_valid_next = 1'b1;
                    m_kind_next  = acr_pkg::KIND_FINISHED;
                    m_dir_next   = acr_pkg::DIR_NONE;
                    m_depth_next = '0;
                    m_x_next     = run_x_reg;
                    m_y_next     = run_y_reg;
                    m_last_next  = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            idx_reg     <= '0;
            full_reg    <= 1'b0;
            run_x_reg   <= '0;
            run_y_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            idx_reg     <= idx_next;
            full_reg    <= full_next;
            run_x_reg   <= run_x_next;
            run_y_reg   <= run_y_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            query_reg <= in_box;
        end
        m_kind_reg  <= m_kind_next;
        m_dir_reg   <= m_dir_next;
        m_depth_reg <= m_depth_next;
        m_x_reg     <= m_x_next;
        m_y_reg     <= m_y_next;
        m_last_reg  <= m_last_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_kind      = m_kind_reg;
    assign m_direction = m_dir_reg;
    assign m_depth     = m_depth_reg;
    assign m_new_pos_x = m_x_reg;
    assign m_new_pos_y = m_y_reg;
    assign m_last      = m_last_reg;

    `ACR_CHECK(a_count_bound, 1'b1, count_reg <= CNT_W'(MAX_BOXES), "box count past table size")
    `ACR_CHECK(a_walk_bound, state_reg != ST_IDLE, idx_reg <= count_reg, "walk index past box count")
    `ACR_CHECK(a_last_kind, m_valid_reg, m_last_reg == (m_kind_reg != acr_pkg::KIND_COLLISION), "last flag disagrees with kind")
    `ACR_CHECK_NEXT(a_full_hold, s_fire && (s_command == acr_pkg::CMD_STORE) && table_full, count_reg == $past(count_reg), "store into full table changed count")
    `ACR_CHECK_NEXT(a_busy_after_take, s_fire, !s_ready, "ready while item in progress")

endmodule
